### rtl/core/jtsd_pkg.sv
// Package: shared types and constants of the JPEG table segment dedup unit.
`timescale 1ns / 1ps

package jtsd_pkg;

	// Marker codes
	localparam logic [7:0] MK_PREFIX = 8'hff;
	localparam logic [7:0] MK_TEM    = 8'h01;
	localparam logic [7:0] MK_RST0   = 8'hd0;
	localparam logic [7:0] MK_EOI    = 8'hd9;
	localparam logic [7:0] MK_DHT    = 8'hc4;
	localparam logic [7:0] MK_DQT    = 8'hdb;
	localparam logic [7:0] MK_SOS    = 8'hda;

	// Output beat layout
	localparam int WORD_BITS = 128;
	localparam int CNT_BITS  = 5;
	localparam int TDATA_BITS = 136;

	// Parser phase
	typedef enum logic [3:0] {
		PH_PREFIX = 4'd0,
		PH_TYPE   = 4'd1,
		PH_LEN_HI = 4'd2,
		PH_LEN_LO = 4'd3,
		PH_BODY   = 4'd4,
		PH_SCAN   = 4'd5,
		PH_SKIP   = 4'd6
	} phase_t;

	// Source of a result beat
	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_BYTE = 2'd1,
		SRC_PAIR = 2'd2,
		SRC_WORD = 2'd3
	} put_src_t;

	// Segment length register update
	typedef enum logic [1:0] {
		SEG_HOLD      = 2'd0,
		SEG_SET_HI    = 2'd1,
		SEG_SET_TOTAL = 2'd2,
		SEG_DEC       = 2'd3
	} seg_op_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_FLUSH,
		ST_FRD,
		ST_FACC,
		ST_FPUT,
		ST_TYPE2,
		ST_TRD1,
		ST_TCMP1,
		ST_TRD2,
		ST_TCMP2,
		ST_BRD,
		ST_BCMP,
		ST_POST
	} ctrl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     load_in;
		logic     set_held;
		logic     phase_wr;
		phase_t   phase_val;
		seg_op_t  seg_op;
		logic     put;
		put_src_t put_src;
		logic     put_last;
		logic     put_done;
		logic     put_err;
		logic     abandon;
		logic     store_held;
		logic     rd_flush;
		logic     cmp_wr;
		logic     set_kind;
		logic     flush_begin;
		logic     flush_rd;
		logic     flush_acc;
		logic     run_clear;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		phase_t phase;
		logic   in_end;
		logic   is_prefix;
		logic   is_table;
		logic   kind_match;
		logic   is_standalone;
		logic   is_sos;
		logic   run_active;
		logic   run_full;
		logic   flush_needed;
		logic   flush_last;
		logic   word_full;
		logic   total_short;
		logic   lo_rem_zero;
		logic   body_rem_zero;
		logic   out_free;
	} dp_stat_t;

endpackage

### rtl/core/jtsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module jtsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/jtsd_datapath.sv
// Datapath: parse registers, table stores, flush word builder and output register.
`timescale 1ns / 1ps

module jtsd_datapath #(
	parameter int TABLE_BYTES = 512
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  jtsd_pkg::dp_cmd_t                   cmd,
	output jtsd_pkg::dp_stat_t                  stat,
	input  logic [7:0]                          s_tdata,
	input  logic                                s_tlast,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [jtsd_pkg::TDATA_BITS-1:0]     m_tdata,
	output logic                                m_tlast,
	output logic [1:0]                          m_tuser
);

	import jtsd_pkg::*;

	localparam int AW = $clog2(TABLE_BYTES);
	localparam int CW = $clog2(TABLE_BYTES + 1);

	logic [7:0]           byte_q;
	logic                 end_q;
	logic [7:0]           held_q;
	phase_t               phase_q;
	logic [15:0]          seg_rem_q;
	logic [CW-1:0]        run_count_q;
	logic                 run_differs_q;
	logic                 run_is_quant_q;
	logic [CW-1:0]        huff_len_q;
	logic [CW-1:0]        quant_len_q;
	logic [CW-1:0]        fl_ptr_q;
	logic [CNT_BITS-1:0]  fill_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_word_q;
	logic [CNT_BITS-1:0]  out_cnt_q;
	logic                 out_last_q;
	logic                 out_done_q;
	logic                 out_err_q;

	logic [CW-1:0] cur_len;
	logic [7:0]    store_b;
	logic [AW-1:0] rd_addr;
	logic [7:0]    h_rdata;
	logic [7:0]    q_rdata;
	logic [7:0]    cur_rdata;
	logic [15:0]   total;
	logic          run_active;
	logic          h_we;
	logic          q_we;

	// Current run selection and derived values
	always_comb begin
		cur_len    = run_is_quant_q ? quant_len_q : huff_len_q;
		store_b    = cmd.store_held ? held_q : byte_q;
		rd_addr    = cmd.rd_flush ? fl_ptr_q[AW-1:0] : run_count_q[AW-1:0];
		cur_rdata  = run_is_quant_q ? q_rdata : h_rdata;
		total      = {seg_rem_q[15:8], byte_q};
		run_active = (run_count_q != '0);
		h_we       = cmd.cmp_wr && !run_is_quant_q;
		q_we       = cmd.cmp_wr && run_is_quant_q;
	end

	// Status to controller
	always_comb begin
		stat.phase         = phase_q;
		stat.in_end        = end_q;
		stat.is_prefix     = (byte_q == MK_PREFIX);
		stat.is_table      = (byte_q == MK_DHT) || (byte_q == MK_DQT);
		stat.kind_match    = ((byte_q == MK_DQT) == run_is_quant_q);
		stat.is_standalone = (byte_q == MK_TEM) || ((byte_q >= MK_RST0) && (byte_q <= MK_EOI));
		stat.is_sos        = (byte_q == MK_SOS);
		stat.run_active    = run_active;
		stat.run_full      = (run_count_q >= CW'(TABLE_BYTES));
		stat.flush_needed  = run_differs_q || (run_count_q != cur_len);
		stat.flush_last    = (fl_ptr_q == run_count_q);
		stat.word_full     = (fill_q == CNT_BITS'(15));
		stat.total_short   = (total < 16'd2);
		stat.lo_rem_zero   = (total == 16'd2);
		stat.body_rem_zero = (seg_rem_q <= 16'd1);
		stat.out_free      = !out_valid_q || m_tready;
	end

	// Table stores
	jtsd_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_huff_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (run_count_q[AW-1:0]),
		.wdata (store_b),
		.raddr (rd_addr),
		.rdata (h_rdata)
	);

	jtsd_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_quant_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (run_count_q[AW-1:0]),
		.wdata (store_b),
		.raddr (rd_addr),
		.rdata (q_rdata)
	);

	// Input beat, parse state and run bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q         <= '0;
			end_q          <= 1'b0;
			held_q         <= '0;
			phase_q        <= PH_PREFIX;
			seg_rem_q      <= '0;
			run_count_q    <= '0;
			run_differs_q  <= 1'b0;
			run_is_quant_q <= 1'b0;
			huff_len_q     <= '0;
			quant_len_q    <= '0;
			fl_ptr_q       <= '0;
			fill_q         <= '0;
			word_q         <= '0;
		end else begin
			if (cmd.load_in) begin
				byte_q <= s_tdata;
				end_q  <= s_tlast;
			end
			if (cmd.set_held) begin
				held_q <= byte_q;
			end
			if (cmd.phase_wr) begin
				phase_q <= cmd.phase_val;
			end
			unique case (cmd.seg_op)
				SEG_SET_HI:    seg_rem_q <= {byte_q, 8'h00};
				SEG_SET_TOTAL: seg_rem_q <= total - 16'd2;
				SEG_DEC:       seg_rem_q <= (seg_rem_q != '0) ? seg_rem_q - 16'd1 : seg_rem_q;
				default:       seg_rem_q <= seg_rem_q;
			endcase
			if (cmd.set_kind) begin
				run_is_quant_q <= (byte_q == MK_DQT);
				run_differs_q  <= 1'b0;
			end
			// compare with the kept run, then store and advance
			if (cmd.cmp_wr) begin
				if ((run_count_q >= cur_len) || (cur_rdata != store_b)) begin
					run_differs_q <= 1'b1;
				end
				run_count_q <= run_count_q + CW'(1);
			end
			if (cmd.abandon) begin
				if (run_active) begin
					if (run_is_quant_q) begin
						quant_len_q <= '0;
					end else begin
						huff_len_q <= '0;
					end
				end
				run_count_q   <= '0;
				run_differs_q <= 1'b0;
			end
			if (cmd.run_clear) begin
				run_count_q   <= '0;
				run_differs_q <= 1'b0;
			end
			// flush word builder
			if (cmd.flush_begin) begin
				if (run_is_quant_q) begin
					quant_len_q <= run_count_q;
				end else begin
					huff_len_q <= run_count_q;
				end
				fl_ptr_q <= '0;
				fill_q   <= '0;
				word_q   <= '0;
			end
			if (cmd.flush_rd) begin
				fl_ptr_q <= fl_ptr_q + CW'(1);
			end
			if (cmd.flush_acc) begin
				word_q[fill_q[3:0]*8 +: 8] <= cur_rdata;
				fill_q <= fill_q + CNT_BITS'(1);
			end
			if (cmd.put && (cmd.put_src == SRC_WORD)) begin
				fill_q <= '0;
				word_q <= '0;
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.put) begin
			out_last_q <= cmd.put_last;
			out_done_q <= cmd.put_done;
			out_err_q  <= cmd.put_err;
			unique case (cmd.put_src)
				SRC_BYTE: begin
					out_word_q <= {{(WORD_BITS-8){1'b0}}, byte_q};
					out_cnt_q  <= CNT_BITS'(1);
				end
				SRC_PAIR: begin
					out_word_q <= {{(WORD_BITS-16){1'b0}}, byte_q, held_q};
					out_cnt_q  <= CNT_BITS'(2);
				end
				SRC_WORD: begin
					out_word_q <= word_q;
					out_cnt_q  <= fill_q;
				end
				default: begin
					out_word_q <= '0;
					out_cnt_q  <= '0;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_BITS-WORD_BITS-CNT_BITS){1'b0}}, out_cnt_q, out_word_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_err_q, out_done_q};

`ifndef NO_ASSERTIONS
	// a run never grows past the store
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_count_q <= CW'(TABLE_BYTES))
		else $error("run count beyond table store");

	// the word builder never holds more than one beat
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_BITS'(16))
		else $error("flush word overfilled");

	// an error beat carries no bytes
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_err_q |-> out_cnt_q == '0)
		else $error("error beat with data");

	// a new beat is loaded only when the previous one is gone
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> !out_valid_q || m_tready)
		else $error("output beat overwritten");
`endif

endmodule

### rtl/core/jtsd_ctrl.sv
// Controller: sequences the parse of one input beat and the flush of a table run.
`timescale 1ns / 1ps

module jtsd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  jtsd_pkg::dp_stat_t stat,
	output jtsd_pkg::dp_cmd_t  cmd
);

	import jtsd_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.phase)
					PH_SKIP: begin
						if (!stat.in_end) begin
							state_d = ST_IDLE;
						end else if (stat.out_free) begin
							cmd.put       = 1'b1;
							cmd.put_src   = SRC_NONE;
							cmd.put_last  = 1'b1;
							cmd.put_done  = 1'b1;
							cmd.phase_wr  = 1'b1;
							cmd.phase_val = PH_PREFIX;
							state_d       = ST_IDLE;
						end
					end
					PH_SCAN: begin
						if (stat.out_free) begin
							cmd.put       = 1'b1;
							cmd.put_src   = SRC_BYTE;
							cmd.put_last  = 1'b1;
							cmd.put_done  = stat.in_end;
							cmd.phase_wr  = stat.in_end;
							cmd.phase_val = PH_PREFIX;
							state_d       = ST_IDLE;
						end
					end
					PH_PREFIX, PH_TYPE, PH_LEN_HI, PH_LEN_LO, PH_BODY: begin
						if (stat.in_end) begin
							// early end of image
							if (stat.out_free) begin
								cmd.abandon   = 1'b1;
								cmd.put       = 1'b1;
								cmd.put_src   = SRC_NONE;
								cmd.put_last  = 1'b1;
								cmd.put_done  = 1'b1;
								cmd.put_err   = 1'b1;
								cmd.phase_wr  = 1'b1;
								cmd.phase_val = PH_PREFIX;
								state_d       = ST_IDLE;
							end
						end else if (stat.phase == PH_PREFIX) begin
							if (stat.is_prefix) begin
								cmd.set_held  = 1'b1;
								cmd.phase_wr  = 1'b1;
								cmd.phase_val = PH_TYPE;
								state_d       = ST_IDLE;
							end else if (stat.out_free) begin
								cmd.abandon   = 1'b1;
								cmd.put       = 1'b1;
								cmd.put_src   = SRC_NONE;
								cmd.put_last  = 1'b1;
								cmd.put_err   = 1'b1;
								cmd.phase_wr  = 1'b1;
								cmd.phase_val = PH_SKIP;
								state_d       = ST_IDLE;
							end
						end else if (stat.phase == PH_TYPE) begin
							if (stat.run_active && !(stat.is_table && stat.kind_match)) begin
								state_d = ST_FLUSH;
							end else begin
								state_d = ST_TYPE2;
							end
						end else if (stat.run_active) begin
							// length or body byte joins the table run
							if (!stat.run_full) begin
								state_d = ST_BRD;
							end else if (stat.out_free) begin
								cmd.abandon   = 1'b1;
								cmd.put       = 1'b1;
								cmd.put_src   = SRC_NONE;
								cmd.put_last  = 1'b1;
								cmd.put_err   = 1'b1;
								cmd.phase_wr  = 1'b1;
								cmd.phase_val = PH_SKIP;
								state_d       = ST_IDLE;
							end
						end else if (stat.out_free) begin
							cmd.put      = 1'b1;
							cmd.put_src  = SRC_BYTE;
							cmd.put_last = !((stat.phase == PH_LEN_LO) && stat.total_short);
							state_d      = ST_POST;
						end
					end
					default: begin
						cmd.phase_wr  = 1'b1;
						cmd.phase_val = PH_PREFIX;
						state_d       = ST_IDLE;
					end
				endcase
			end
			// run ended: drop it or send it out
			ST_FLUSH: begin
				if (stat.flush_needed) begin
					cmd.flush_begin = 1'b1;
					state_d         = ST_FRD;
				end else begin
					cmd.run_clear = 1'b1;
					state_d       = ST_TYPE2;
				end
			end
			ST_FRD: begin
				cmd.rd_flush = 1'b1;
				cmd.flush_rd = 1'b1;
				state_d      = ST_FACC;
			end
			ST_FACC: begin
				cmd.flush_acc = 1'b1;
				if (stat.word_full || stat.flush_last) begin
					state_d = ST_FPUT;
				end else begin
					state_d = ST_FRD;
				end
			end
			ST_FPUT: begin
				if (stat.out_free) begin
					cmd.put      = 1'b1;
					cmd.put_src  = SRC_WORD;
					cmd.put_last = stat.flush_last && stat.is_table;
					if (stat.flush_last) begin
						cmd.run_clear = 1'b1;
						state_d       = ST_TYPE2;
					end else begin
						state_d = ST_FRD;
					end
				end
			end
			// marker type after any flush
			ST_TYPE2: begin
				if (stat.is_table) begin
					cmd.set_kind = !stat.run_active;
					state_d      = ST_TRD1;
				end else if (stat.out_free) begin
					cmd.put      = 1'b1;
					cmd.put_src  = SRC_PAIR;
					cmd.put_last = 1'b1;
					cmd.phase_wr = 1'b1;
					if (stat.is_standalone) begin
						cmd.phase_val = PH_PREFIX;
					end else if (stat.is_sos) begin
						cmd.phase_val = PH_SCAN;
					end else begin
						cmd.phase_val = PH_LEN_HI;
					end
					state_d = ST_IDLE;
				end
			end
			ST_TRD1, ST_TRD2: begin
				cmd.store_held = (state_q == ST_TRD1);
				if (!stat.run_full) begin
					state_d = (state_q == ST_TRD1) ? ST_TCMP1 : ST_TCMP2;
				end else if (stat.out_free) begin
					cmd.abandon   = 1'b1;
					cmd.put       = 1'b1;
					cmd.put_src   = SRC_NONE;
					cmd.put_last  = 1'b1;
					cmd.put_err   = 1'b1;
					cmd.phase_wr  = 1'b1;
					cmd.phase_val = PH_SKIP;
					state_d       = ST_IDLE;
				end
			end
			ST_TCMP1: begin
				cmd.store_held = 1'b1;
				cmd.cmp_wr     = 1'b1;
				state_d        = ST_TRD2;
			end
			ST_TCMP2: begin
				cmd.cmp_wr    = 1'b1;
				cmd.phase_wr  = 1'b1;
				cmd.phase_val = PH_LEN_HI;
				state_d       = ST_IDLE;
			end
			ST_BRD: begin
				state_d = ST_BCMP;
			end
			ST_BCMP: begin
				cmd.cmp_wr = 1'b1;
				state_d    = ST_POST;
			end
			// length and body bookkeeping after the byte was taken
			ST_POST: begin
				unique case (stat.phase)
					PH_LEN_HI: begin
						cmd.seg_op    = SEG_SET_HI;
						cmd.phase_wr  = 1'b1;
						cmd.phase_val = PH_LEN_LO;
						state_d       = ST_IDLE;
					end
					PH_LEN_LO: begin
						if (!stat.total_short) begin
							cmd.seg_op    = SEG_SET_TOTAL;
							cmd.phase_wr  = 1'b1;
							cmd.phase_val = stat.lo_rem_zero ? PH_PREFIX : PH_BODY;
							state_d       = ST_IDLE;
						end else if (stat.out_free) begin
							cmd.abandon   = 1'b1;
							cmd.put       = 1'b1;
							cmd.put_src   = SRC_NONE;
							cmd.put_last  = 1'b1;
							cmd.put_err   = 1'b1;
							cmd.phase_wr  = 1'b1;
							cmd.phase_val = PH_SKIP;
							state_d       = ST_IDLE;
						end
					end
					default: begin
						cmd.seg_op    = SEG_DEC;
						cmd.phase_wr  = 1'b1;
						cmd.phase_val = stat.body_rem_zero ? PH_PREFIX : PH_BODY;
						state_d       = ST_IDLE;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// input is taken only when the controller is idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |-> state_q == ST_IDLE)
		else $error("beat accepted while busy");

	// every accepted beat is dispatched next
	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> state_q == ST_DISPATCH)
		else $error("accepted beat not dispatched");

	// a store write always follows its read
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp_wr |-> $past(state_q) == ST_TRD1 || $past(state_q) == ST_TRD2 ||
			$past(state_q) == ST_BRD)
		else $error("store written without prior read");
`endif

endmodule

### rtl/core/jpeg_table_segment_dedup_unit.sv
// A pass-through byte is loaded, put in dispatch and registered as an output beat; a
// marker pair is put from the marker type state; a stored table byte gives no beat. A beat
// is taken only when idle: prefix and scan beats pass dispatch, other pass-through bytes
// also post, a table byte read, compare and post, a table marker type two read-compares;
// a flush reads each byte of the single-read store and puts each word; stalls add.
// Reset: arst_n clears parse state and kept run lengths at once; no clearing pass.
`timescale 1ns / 1ps

module jpeg_table_segment_dedup_unit #(
	parameter int TABLE_BYTES = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] stream_byte
	input  logic                            s_tlast,  // image_end
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [63:0] word_low, [127:64] word_high, [132:128] byte_count, rest zero
	output logic [jtsd_pkg::TDATA_BITS-1:0] m_tdata,
	output logic                            m_tlast,  // final_of_burst
	output logic [1:0]                      m_tuser   // [0] image_done, [1] format_error
);

	import jtsd_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	jtsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	jtsd_datapath #(.TABLE_BYTES(TABLE_BYTES)) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
